FILE: rtl/oph_pkg.sv
package oph_pkg;

    localparam int DIGIT_W     = 3;
    localparam int DIM_W       = 3;
    localparam int DELAY_W     = 4;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 4;
    localparam int OUT_COUNT_W = 32;
    localparam int DIM_RESET   = 3;
    localparam int DELAY_RESET = 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_EMBED_DIM   = 2'd0,
        CFG_EMBED_DELAY = 2'd1,
        CFG_NAN_AWARE   = 2'd2
    } t_cfg_idx;

    typedef enum logic [3:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_WRITE,
        BK_READ,
        BK_CHECK,
        BK_SEL,
        BK_RANK,
        BK_HREAD,
        BK_HWRITE,
        BK_OUT
    } t_back_state;

    function automatic int oph_fact(input int n);
        int f;
        f = 1;
        for (int k = 2; k <= 8; k++) begin
            if (k <= n) f = f * k;
        end
        return f;
    endfunction

endpackage

FILE: rtl/oph_in_if.sv
interface oph_in_if #(parameter int SAMPLE_BITS = 16);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          sample_is_nan;
    logic                          new_series;

    modport source(output valid, sample, sample_is_nan, new_series, input ready);
    modport sink(input valid, sample, sample_is_nan, new_series, output ready);
endinterface

FILE: rtl/oph_out_if.sv
interface oph_out_if #(parameter int MAX_DIM = 6);
    import oph_pkg::*;
    localparam int PW = DIGIT_W * MAX_DIM;
    localparam int RW = $clog2(oph_fact(MAX_DIM));

    logic                   valid;
    logic                   ready;
    logic [PW-1:0]          pattern_packed;
    logic [RW-1:0]          pattern_rank;
    logic                   pattern_valid;
    logic [OUT_COUNT_W-1:0] pattern_count;

    modport source(output valid, pattern_packed, pattern_rank, pattern_valid, pattern_count,
                   input ready);
    modport sink(input valid, pattern_packed, pattern_rank, pattern_valid, pattern_count,
                 output ready);
endinterface

FILE: rtl/oph_ram.sv
module oph_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule

FILE: rtl/oph_queue.sv
module oph_queue #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);
    logic [WIDTH-1:0] r_mem [2];
    logic             r_wr;
    logic             r_rd;
    logic [1:0]       r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) r_mem[r_wr] <= i_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push && !o_full) r_wr <= ~r_wr;
            if (i_pop && o_valid)  r_rd <= ~r_rd;
            case ({i_push && !o_full, i_pop && o_valid})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end
endmodule

FILE: rtl/oph_front.sv
module oph_front #(
    parameter int MAX_DIM     = 6,
    parameter int MAX_DELAY   = 8,
    parameter int SAMPLE_BITS = 16,
    localparam int TW    = $clog2(MAX_DELAY + 1),
    localparam int CMD_W = SAMPLE_BITS + 4 + oph_pkg::DIM_W + TW
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [oph_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [oph_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    oph_in_if.sink                          i_in,
    input  logic                            i_clear_busy,
    input  logic                            i_cmd_full,
    output logic                            o_cmd_push,
    output logic [CMD_W-1:0]                o_cmd
);
    import oph_pkg::*;

    localparam int LD = (MAX_DIM - 1) * MAX_DELAY + 1;
    localparam int FW = $clog2(LD + 1);

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          nan;
        logic                          new_series;
        logic                          emit;
        logic [DIM_W-1:0]              dim;
        logic [TW-1:0]                 tau;
        logic                          nan_aware;
    } t_cmd;

    logic [DIM_W-1:0]   r_dim_raw;
    logic [DELAY_W-1:0] r_delay_raw;
    logic               r_nan_aware;
    logic [FW-1:0]      r_fill;

    logic [DIM_W-1:0] dim;
    logic [TW-1:0]    tau;
    logic [FW-1:0]    fill_base;
    logic [FW-1:0]    n_fill;
    logic [FW-1:0]    span;
    logic             accept;
    t_cmd             cmd;

    always_comb begin
        if (r_dim_raw < DIM_W'(2))            dim = DIM_W'(2);
        else if (r_dim_raw > DIM_W'(MAX_DIM)) dim = DIM_W'(MAX_DIM);
        else                                  dim = r_dim_raw;

        if (r_delay_raw == '0)                   tau = TW'(1);
        else if (int'(r_delay_raw) > MAX_DELAY)  tau = TW'(MAX_DELAY);
        else                                     tau = TW'(r_delay_raw);
    end

    assign span = FW'(dim - DIM_W'(1)) * FW'(tau) + FW'(1);

    assign fill_base = i_in.new_series ? '0 : r_fill;
    assign n_fill    = (fill_base < FW'(LD)) ? fill_base + FW'(1) : fill_base;

    assign i_in.ready = !i_cmd_full && !i_clear_busy;
    assign accept     = i_in.valid && i_in.ready;

    always_comb begin
        cmd.sample     = i_in.sample;
        cmd.nan        = i_in.sample_is_nan;
        cmd.new_series = i_in.new_series;
        cmd.emit       = (n_fill >= span);
        cmd.dim        = dim;
        cmd.tau        = tau;
        cmd.nan_aware  = r_nan_aware;
    end

    assign o_cmd_push = accept;
    assign o_cmd      = cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dim_raw   <= DIM_W'(DIM_RESET);
            r_delay_raw <= DELAY_W'(DELAY_RESET);
            r_nan_aware <= 1'b0;
            r_fill      <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_idx))
                    CFG_EMBED_DIM:   r_dim_raw   <= i_cfg_data[DIM_W-1:0];
                    CFG_EMBED_DELAY: r_delay_raw <= i_cfg_data[DELAY_W-1:0];
                    CFG_NAN_AWARE:   r_nan_aware <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (accept) r_fill <= n_fill;
        end
    end
endmodule

FILE: rtl/oph_back.sv
module oph_back #(
    parameter int MAX_DIM     = 6,
    parameter int MAX_DELAY   = 8,
    parameter int SAMPLE_BITS = 16,
    parameter int COUNT_BITS  = 32,
    localparam int TW    = $clog2(MAX_DELAY + 1),
    localparam int CMD_W = SAMPLE_BITS + 4 + oph_pkg::DIM_W + TW
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cmd_valid,
    input  logic [CMD_W-1:0] i_cmd,
    output logic             o_cmd_pop,
    output logic             o_clear_busy,
    oph_out_if.source        o_out
);
    import oph_pkg::*;

    localparam int LD = (MAX_DIM - 1) * MAX_DELAY + 1;
    localparam int AW = $clog2(LD);
    localparam int FW = $clog2(LD + 1);
    localparam int HD = oph_fact(MAX_DIM);
    localparam int HW = $clog2(HD);
    localparam int PW = DIGIT_W * MAX_DIM;
    localparam int EW = SAMPLE_BITS + 1;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          nan;
        logic                          new_series;
        logic                          emit;
        logic [DIM_W-1:0]              dim;
        logic [TW-1:0]                 tau;
        logic                          nan_aware;
    } t_cmd;

    t_back_state r_state, n_state;

    t_cmd                r_cmd;
    t_cmd                cmd_in;
    logic [AW-1:0]       r_wp;
    logic [FW-1:0]       r_age;
    logic [DIM_W-1:0]    r_rc;
    logic [DIM_W-1:0]    r_cj;
    logic [DIM_W-1:0]    r_i;
    logic [EW-1:0]       r_win   [MAX_DIM];
    logic                r_taken [MAX_DIM];
    logic [DIGIT_W-1:0]  r_ord   [MAX_DIM];
    logic [HW-1:0]       r_rank;
    logic [PW-1:0]       r_packed;
    logic [HW-1:0]       r_clr;
    logic                r_pend;
    logic [COUNT_BITS-1:0] r_nan_cnt;

    logic [PW-1:0]         r_res_packed;
    logic [HW-1:0]         r_res_rank;
    logic                  r_res_pvalid;
    logic [COUNT_BITS-1:0] r_res_count;

    logic                   r_ovalid;
    logic [PW-1:0]          r_opacked;
    logic [HW-1:0]          r_orank;
    logic                   r_opvalid;
    logic [OUT_COUNT_W-1:0] r_ocount;

    logic                  line_we;
    logic [AW-1:0]         line_waddr;
    logic [AW-1:0]         line_raddr;
    logic [EW-1:0]         line_rdata;
    logic                  hist_we;
    logic [HW-1:0]         hist_waddr;
    logic [COUNT_BITS-1:0] hist_wdata;
    logic [COUNT_BITS-1:0] hist_rdata;
    logic [COUNT_BITS-1:0] cnt_inc;
    logic [COUNT_BITS-1:0] nan_inc;

    logic [AW-1:0]         wp_next;
    logic [FW:0]           rd_sum;
    logic                  all_nan;
    logic [DIGIT_W-1:0]    pick;
    logic [HW-1:0]         rank_c;
    logic [PW-1:0]         packed_c;
    logic                  out_load;
    logic [OUT_COUNT_W+COUNT_BITS-1:0] res_count_ext;

    assign cmd_in = i_cmd;

    oph_ram #(.WIDTH(EW), .DEPTH(LD)) u_line (
        .i_clk   (i_clk),
        .i_we    (line_we),
        .i_waddr (line_waddr),
        .i_wdata ({r_cmd.nan, r_cmd.sample}),
        .i_raddr (line_raddr),
        .o_rdata (line_rdata)
    );

    oph_ram #(.WIDTH(COUNT_BITS), .DEPTH(HD)) u_hist (
        .i_clk   (i_clk),
        .i_we    (hist_we),
        .i_waddr (hist_waddr),
        .i_wdata (hist_wdata),
        .i_raddr (r_rank),
        .o_rdata (hist_rdata)
    );

    assign wp_next = (r_wp == AW'(LD - 1)) ? '0 : r_wp + AW'(1);

    // circular address of the sample r_age steps back from the newest
    assign rd_sum = {1'b0, FW'(r_wp)} + ((FW'(r_wp) < r_age) ? (FW + 1)'(LD) : '0)
                    - {1'b0, r_age};
    assign line_raddr = AW'(rd_sum);
    assign line_waddr = wp_next;

    assign cnt_inc = (&hist_rdata) ? hist_rdata : hist_rdata + COUNT_BITS'(1);
    assign nan_inc = (&r_nan_cnt) ? r_nan_cnt : r_nan_cnt + COUNT_BITS'(1);

    always_comb begin
        all_nan = 1'b1;
        for (int j = 0; j < MAX_DIM; j++) begin
            if (j < int'(r_cmd.dim) && !r_win[j][EW-1]) all_nan = 1'b0;
        end
    end

    // one selection pass: running minimum over the untaken elements
    always_comb begin
        logic [EW-1:0] pv;
        logic          found;
        pick  = '0;
        pv    = r_win[0];
        found = 1'b0;
        for (int j = 0; j < MAX_DIM; j++) begin
            if (!found && !r_taken[j]) begin
                pick  = DIGIT_W'(j);
                pv    = r_win[j];
                found = 1'b1;
            end
        end
        for (int j = 0; j < MAX_DIM; j++) begin
            if (!r_taken[j] && !r_win[j][EW-1] && !pv[EW-1] &&
                ($signed(r_win[j][SAMPLE_BITS-1:0]) < $signed(pv[SAMPLE_BITS-1:0]))) begin
                pick = DIGIT_W'(j);
                pv   = r_win[j];
            end
        end
    end

    // lehmer code of the finished order
    always_comb begin
        logic [DIM_W-1:0] smaller;
        rank_c   = '0;
        packed_c = '0;
        for (int i = 0; i < MAX_DIM; i++) begin
            smaller = '0;
            if (i < int'(r_cmd.dim)) begin
                for (int k = i + 1; k < MAX_DIM; k++) begin
                    if (k < int'(r_cmd.dim) && r_ord[k] < r_ord[i]) smaller = smaller + DIM_W'(1);
                end
                rank_c = rank_c + HW'(smaller) * HW'(oph_fact(int'(r_cmd.dim) - 1 - i));
                packed_c[i*DIGIT_W +: DIGIT_W] = r_ord[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= BK_CLEAR;
        else          r_state <= n_state;
    end

    always_comb begin
        n_state      = r_state;
        o_cmd_pop    = 1'b0;
        line_we      = 1'b0;
        hist_we      = 1'b0;
        hist_waddr   = r_clr;
        hist_wdata   = '0;
        out_load     = 1'b0;
        o_clear_busy = (r_state == BK_CLEAR);
        unique case (r_state)
            BK_CLEAR: begin
                hist_we = 1'b1;
                if (r_clr == HW'(HD - 1)) n_state = r_pend ? BK_WRITE : BK_IDLE;
            end
            BK_IDLE: begin
                o_cmd_pop = 1'b1;
                if (i_cmd_valid) n_state = cmd_in.new_series ? BK_CLEAR : BK_WRITE;
            end
            BK_WRITE: begin
                line_we = 1'b1;
                n_state = r_cmd.emit ? BK_READ : BK_IDLE;
            end
            BK_READ: begin
                if (r_rc == r_cmd.dim) n_state = BK_CHECK;
            end
            BK_CHECK: begin
                n_state = (r_cmd.nan_aware && all_nan) ? BK_OUT : BK_SEL;
            end
            BK_SEL: begin
                if (r_i == r_cmd.dim - DIM_W'(1)) n_state = BK_RANK;
            end
            BK_RANK:  n_state = BK_HREAD;
            BK_HREAD: n_state = BK_HWRITE;
            BK_HWRITE: begin
                hist_we    = 1'b1;
                hist_waddr = r_rank;
                hist_wdata = cnt_inc;
                n_state    = BK_OUT;
            end
            BK_OUT: begin
                if (!r_ovalid || o_out.ready) begin
                    out_load = 1'b1;
                    n_state  = BK_IDLE;
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr     <= '0;
            r_pend    <= 1'b0;
            r_wp      <= '0;
            r_nan_cnt <= '0;
            r_ovalid  <= 1'b0;
        end else begin
            case (r_state)
                BK_CLEAR: begin
                    r_clr <= r_clr + HW'(1);
                    if (r_clr == HW'(HD - 1)) r_pend <= 1'b0;
                end
                BK_IDLE: begin
                    if (i_cmd_valid && cmd_in.new_series) begin
                        r_clr     <= '0;
                        r_pend    <= 1'b1;
                        r_nan_cnt <= '0;
                    end
                end
                BK_WRITE: r_wp <= wp_next;
                BK_CHECK: begin
                    if (r_cmd.nan_aware && all_nan) r_nan_cnt <= nan_inc;
                end
                default: ;
            endcase
            if (out_load)         r_ovalid <= 1'b1;
            else if (o_out.ready) r_ovalid <= 1'b0;
        end
    end

    assign res_count_ext = {{OUT_COUNT_W{1'b0}}, r_res_count};

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            BK_IDLE: begin
                if (i_cmd_valid) r_cmd <= cmd_in;
            end
            BK_WRITE: begin
                r_rc  <= '0;
                r_age <= '0;
                r_cj  <= r_cmd.dim - DIM_W'(1);
            end
            BK_READ: begin
                if (r_rc != r_cmd.dim) begin
                    r_rc  <= r_rc + DIM_W'(1);
                    r_age <= r_age + FW'(r_cmd.tau);
                end
                if (r_rc != '0) begin
                    r_win[r_cj] <= line_rdata;
                    r_cj        <= r_cj - DIM_W'(1);
                end
            end
            BK_CHECK: begin
                r_i <= '0;
                for (int j = 0; j < MAX_DIM; j++) r_taken[j] <= (j >= int'(r_cmd.dim));
                r_res_packed <= '0;
                r_res_rank   <= '0;
                r_res_pvalid <= 1'b0;
                r_res_count  <= nan_inc;
            end
            BK_SEL: begin
                r_taken[pick] <= 1'b1;
                r_ord[r_i]    <= pick;
                r_i           <= r_i + DIM_W'(1);
            end
            BK_RANK: begin
                r_rank   <= rank_c;
                r_packed <= packed_c;
            end
            BK_HWRITE: begin
                r_res_packed <= r_packed;
                r_res_rank   <= r_rank;
                r_res_pvalid <= 1'b1;
                r_res_count  <= cnt_inc;
            end
            default: ;
        endcase
        if (out_load) begin
            r_opacked <= r_res_packed;
            r_orank   <= r_res_rank;
            r_opvalid <= r_res_pvalid;
            r_ocount  <= res_count_ext[OUT_COUNT_W-1:0];
        end
    end

    assign o_out.valid          = r_ovalid;
    assign o_out.pattern_packed = r_opacked;
    assign o_out.pattern_rank   = r_orank;
    assign o_out.pattern_valid  = r_opvalid;
    assign o_out.pattern_count  = r_ocount;
endmodule

FILE: rtl/ordinal_pattern_histogram_unit.sv
// a word accepted is written to the line ram; one that completes a window of D samples
// has its D taps read back (one tap a cycle), ordered by the selection unit (one pass a
// cycle), ranked and counted in the histogram ram by read-modify-write, then shown; an
// all-nan window in nan-aware mode skips ordering and the histogram; one word is worked at
// a time, and input is still taken until the two-entry queue fills; reset and each new
// series sweep the histogram ram, input held off; regs D=3, tau=1, nan off
module ordinal_pattern_histogram_unit #(
    parameter int MAX_DIM     = 6,
    parameter int MAX_DELAY   = 8,
    parameter int SAMPLE_BITS = 16,
    parameter int COUNT_BITS  = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [oph_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [oph_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    oph_in_if.sink                          i_in,
    oph_out_if.source                       o_out
);
    import oph_pkg::*;

    localparam int TW    = $clog2(MAX_DELAY + 1);
    localparam int CMD_W = SAMPLE_BITS + 4 + DIM_W + TW;

    logic             cmd_push;
    logic [CMD_W-1:0] cmd_in;
    logic             cmd_full;
    logic             cmd_pop;
    logic             cmd_valid;
    logic [CMD_W-1:0] cmd_out;
    logic             clear_busy;

    oph_front #(
        .MAX_DIM     (MAX_DIM),
        .MAX_DELAY   (MAX_DELAY),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_in         (i_in),
        .i_clear_busy (clear_busy),
        .i_cmd_full   (cmd_full),
        .o_cmd_push   (cmd_push),
        .o_cmd        (cmd_in)
    );

    oph_queue #(.WIDTH(CMD_W)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_data  (cmd_in),
        .o_full  (cmd_full),
        .i_pop   (cmd_pop),
        .o_valid (cmd_valid),
        .o_data  (cmd_out)
    );

    oph_back #(
        .MAX_DIM     (MAX_DIM),
        .MAX_DELAY   (MAX_DELAY),
        .SAMPLE_BITS (SAMPLE_BITS),
        .COUNT_BITS  (COUNT_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd_valid  (cmd_valid),
        .i_cmd        (cmd_out),
        .o_cmd_pop    (cmd_pop),
        .o_clear_busy (clear_busy),
        .o_out        (o_out)
    );
endmodule

FILE: rtl/oph_checker.sv
module oph_checker #(
    parameter int MAX_DIM = 6,
    localparam int PW = oph_pkg::DIGIT_W * MAX_DIM,
    localparam int HD = oph_pkg::oph_fact(MAX_DIM),
    localparam int RW = $clog2(HD)
) (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_in_ready,
    input logic                             i_out_valid,
    input logic                             i_out_ready,
    input logic [PW-1:0]                    i_out_packed,
    input logic [RW-1:0]                    i_out_rank,
    input logic                             i_out_pvalid,
    input logic [oph_pkg::OUT_COUNT_W-1:0]  i_out_count
);
    import oph_pkg::*;

    // stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_packed) &&
        $stable(i_out_rank) && $stable(i_out_pvalid) && $stable(i_out_count))
        else $error("result word changed while stalled");

    a_nan_window_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_pvalid |-> (i_out_packed == '0) && (i_out_rank == '0))
        else $error("all-nan window shows a pattern");

    a_rank_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (int'(i_out_rank) < HD))
        else $error("rank beyond pattern count");

    // histogram sweep after reset holds off input and output
    a_sweep_after_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !i_in_ready && !i_out_valid)
        else $error("activity during post-reset sweep");
endmodule

bind ordinal_pattern_histogram_unit oph_checker #(.MAX_DIM(MAX_DIM)) u_oph_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_out_packed (o_out.pattern_packed),
    .i_out_rank   (o_out.pattern_rank),
    .i_out_pvalid (o_out.pattern_valid),
    .i_out_count  (o_out.pattern_count)
);
